### rtl/crcfr_pkg.sv
package crcfr_pkg;

   localparam int MAX_FRAME_BYTES = 64;
   localparam int BUF_DEPTH       = 32;
   localparam int BUF_AW          = $clog2(BUF_DEPTH);
   localparam int COUNT_W         = 7;
   localparam int SCAN_W          = BUF_AW + 1;
   localparam int CRC_LEN         = 28;
   localparam int ZERO_FIRST      = 24;
   localparam int CRC_HI_POS      = 28;
   localparam int CRC_LO_POS      = 29;
   localparam int CR_POS          = 30;
   localparam int LF_POS          = 31;
   localparam int PAY_FIRST       = 2;
   localparam int PAY_LEN         = 12;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] RUN_MAX  = 16'hFFFF;
   localparam logic [7:0]  CHAR_CR  = 8'h0d;
   localparam logic [7:0]  CHAR_LF  = 8'h0a;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_IDLE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        frame_ok;
      logic [15:0] fail_run;
      logic [7:0]  mode_a;
      logic [7:0]  mode_b;
      logic [7:0]  a_x;
      logic [7:0]  a_y;
      logic [7:0]  b_x;
      logic [7:0]  b_y;
      logic [15:0] p1_xy;
      logic [15:0] p2_xy;
      logic [15:0] ball_xy;
   } rsp_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      c = crc ^ {8'h00, d};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/crcfr_ram.sv
module crcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/crc_checked_frame_receiver.sv
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_stall | req_data  (req_type: op, rx_byte)
// rsp     | out       | rsp_valid / rsp_stall | rsp_data  (rsp_type: one per line idle)
//
// On a line idle the frame buffer RAM is read one byte per cycle over 32 entries,
// each of the first 28 bytes going through the CRC in the cycle after its read,
// then the ST_DONE state checks the frame and latches the result.
// Reset is synchronous and clears the buffer valid bits, count, run and latches.
// A result waits in the output register while rsp_stall is high; bytes and the
// next idle scan are still taken, and the check cycle holds until it is free.
module crc_checked_frame_receiver
   import crcfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     byte_count_ff, byte_count_in;
   logic [BUF_DEPTH-1:0]   valid_ff, valid_in;
   logic [SCAN_W-1:0]      scan_cnt_ff, scan_cnt_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [BUF_AW-1:0]      rd_idx_ff, rd_idx_in;
   logic [15:0]            crc_ff, crc_in;
   logic [15:0]            rx_crc_ff, rx_crc_in;
   logic                   zero_ok_ff, zero_ok_in;
   logic                   tail_ok_ff, tail_ok_in;
   logic [7:0]             pay_ff [PAY_LEN];
   logic [7:0]             pay_in [PAY_LEN];
   logic [7:0]             latched_ff [PAY_LEN];
   logic [7:0]             latched_in [PAY_LEN];
   logic [15:0]            run_ff, run_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   req_take;
   logic                   wr_en;
   logic [BUF_AW-1:0]      wr_addr;
   logic [7:0]             wr_data;
   logic                   rd_en;
   logic [BUF_AW-1:0]      rd_addr;
   logic [7:0]             rd_data;
   logic [7:0]             byte_d;
   logic                   frame_ok;

   crcfr_ram #(
      .WIDTH(8),
      .DEPTH(BUF_DEPTH)
   ) u_frame_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign byte_d    = valid_ff[rd_idx_ff] ? rd_data : 8'h00;
   assign frame_ok  = zero_ok_ff && tail_ok_ff && (crc_ff == rx_crc_ff);

   always_comb begin
      state_in      = state_ff;
      byte_count_in = byte_count_ff;
      valid_in      = valid_ff;
      scan_cnt_in   = scan_cnt_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      crc_in        = crc_ff;
      rx_crc_in     = rx_crc_ff;
      zero_ok_in    = zero_ok_ff;
      tail_ok_in    = tail_ok_ff;
      pay_in        = pay_ff;
      latched_in    = latched_ff;
      run_in        = run_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = byte_count_ff[BUF_AW-1:0];
      wr_data       = 8'h00;
      rd_en         = 1'b0;
      rd_addr       = scan_cnt_ff[BUF_AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.op == OP_BYTE) begin
                  if (byte_count_ff < COUNT_W'(MAX_FRAME_BYTES)) begin
                     byte_count_in = byte_count_ff + 1'b1;
                     if (byte_count_ff < COUNT_W'(BUF_DEPTH)) begin
                        wr_en    = 1'b1;
                        wr_data  = req_data.rx_byte;
                        valid_in[byte_count_ff[BUF_AW-1:0]] = 1'b1;
                     end
                  end
               end else begin
                  if (byte_count_ff < COUNT_W'(BUF_DEPTH)) begin
                     wr_en   = 1'b1;
                     valid_in[byte_count_ff[BUF_AW-1:0]] = 1'b1;
                  end
                  byte_count_in = '0;
                  scan_cnt_in   = '0;
                  crc_in        = CRC_INIT;
                  zero_ok_in    = 1'b1;
                  tail_ok_in    = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!scan_cnt_ff[SCAN_W-1]) begin
               rd_en       = 1'b1;
               rd_pend_in  = 1'b1;
               rd_idx_in   = scan_cnt_ff[BUF_AW-1:0];
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
            if (rd_pend_ff) begin
               if (rd_idx_ff < BUF_AW'(CRC_LEN)) begin
                  crc_in = crc_byte(crc_ff, byte_d);
               end
               if (rd_idx_ff >= BUF_AW'(ZERO_FIRST) && rd_idx_ff < BUF_AW'(CRC_LEN)
                   && byte_d != 8'h00) begin
                  zero_ok_in = 1'b0;
               end
               if (rd_idx_ff == BUF_AW'(CRC_HI_POS)) begin
                  rx_crc_in[15:8] = byte_d;
               end
               if (rd_idx_ff == BUF_AW'(CRC_LO_POS)) begin
                  rx_crc_in[7:0] = byte_d;
               end
               if (rd_idx_ff == BUF_AW'(CR_POS) && byte_d != CHAR_CR) begin
                  tail_ok_in = 1'b0;
               end
               if (rd_idx_ff == BUF_AW'(LF_POS) && byte_d != CHAR_LF) begin
                  tail_ok_in = 1'b0;
               end
               for (int k = 0; k < PAY_LEN; k++) begin
                  if (rd_idx_ff == BUF_AW'(k + PAY_FIRST)) begin
                     pay_in[k] = byte_d;
                  end
               end
            end
         end
         ST_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               if (frame_ok) begin
                  latched_in = pay_ff;
                  run_in     = '0;
               end else begin
                  if (run_ff != RUN_MAX) begin
                     run_in = run_ff + 1'b1;
                  end
                  latched_in[2] = 8'h00;
                  latched_in[3] = 8'h00;
                  latched_in[4] = 8'h00;
                  latched_in[5] = 8'h00;
               end
               rsp_valid_in         = 1'b1;
               rsp_data_in.frame_ok = frame_ok;
               rsp_data_in.fail_run = run_in;
               rsp_data_in.mode_a   = latched_in[0];
               rsp_data_in.mode_b   = latched_in[1];
               rsp_data_in.a_x      = latched_in[2];
               rsp_data_in.a_y      = latched_in[3];
               rsp_data_in.b_x      = latched_in[4];
               rsp_data_in.b_y      = latched_in[5];
               rsp_data_in.p1_xy    = {latched_in[6], latched_in[7]};
               rsp_data_in.p2_xy    = {latched_in[8], latched_in[9]};
               rsp_data_in.ball_xy  = {latched_in[10], latched_in[11]};
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         byte_count_ff <= '0;
         valid_ff      <= '0;
         scan_cnt_ff   <= '0;
         rd_pend_ff    <= 1'b0;
         run_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < PAY_LEN; k++) begin
            latched_ff[k] <= 8'h00;
         end
      end else begin
         state_ff      <= state_in;
         byte_count_ff <= byte_count_in;
         valid_ff      <= valid_in;
         scan_cnt_ff   <= scan_cnt_in;
         rd_pend_ff    <= rd_pend_in;
         run_ff        <= run_in;
         rsp_valid_ff  <= rsp_valid_in;
         latched_ff    <= latched_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      crc_ff      <= crc_in;
      rx_crc_ff   <= rx_crc_in;
      zero_ok_ff  <= zero_ok_in;
      tail_ok_ff  <= tail_ok_in;
      pay_ff      <= pay_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= COUNT_W'(MAX_FRAME_BYTES))
      else $error("byte count past frame limit");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared without a frame check");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.frame_ok |-> rsp_data_ff.fail_run == 16'h0000)
      else $error("accepted frame with nonzero failure run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.frame_ok |->
         rsp_data_ff.a_x == 8'h00 && rsp_data_ff.a_y == 8'h00 &&
         rsp_data_ff.b_x == 8'h00 && rsp_data_ff.b_y == 8'h00)
      else $error("rejected frame kept coordinates");

endmodule
